### design/irac_pkg.sv
`default_nettype none
package irac_pkg;

   localparam int MAX_RUNS = 1024;
   localparam int IDX_BITS = $clog2(MAX_RUNS);
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int POS_BITS = 30;
   localparam logic [POS_BITS-1:0] DOMAIN_RESET = POS_BITS'(1024);

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [POS_BITS-1:0] start;
      logic                mark;
   } run_entry_type;

endpackage
`default_nettype wire

### design/interval_range_assign_count_top.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     cmd, range_first, range_last
// rsp_      out        rsp_tvalid/tready     marked_count, status
// csr_      in         csr_valid/ready       domain_size
//
// An item holds the block from its transfer until the next ready cycle: the R
// runs in use are scanned, one run table read per cycle, then the run table is
// rewritten. A second run is written when the range splits the run behind it,
// and when the run count changes the T runs behind the range move first (one
// read and one write a cycle over the single ports). A bad range answers
// before the scan, a full table after it. Reset and a csr write rewrite entry
// 0 in the init state. One item is in work at a time; a result waits in its
// output register without blocking the next transfer on req_, and only the
// following result stalls behind it.
module interval_range_assign_count_top (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [63:0]              req_tdata,   // cmd, range_first, range_last
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [31:0]              rsp_tdata,   // marked_count, status
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [irac_pkg::POS_BITS-1:0] csr_data  // domain_size
);
   import irac_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CHECK, S_SCAN, S_FULL, S_COPY, S_NEW0, S_NEW1, S_FIN
   } state_type;

   state_type               state_ff;
   logic [POS_BITS-1:0]     domain_ff, total_ff, removed_ff, len_ff;
   logic [CNT_BITS-1:0]     runs_ff, new_runs_ff;
   logic                    cmd_ff;
   logic [POS_BITS-1:0]     first_ff, last_ff;
   logic [CNT_BITS-1:0]     scan_ff, i_ff, j_ff, p_ff;
   logic                    have_prev_ff, left_ff, right_ff, mj_ff;
   run_entry_type           prev_ff;
   logic                    acc_v_ff;
   logic [POS_BITS-1:0]     lo_ff, hi_ff;
   logic [CNT_BITS-1:0]     cp_src_ff, cp_dst_ff, cnt_ff, pend_dst_ff;
   logic                    dir_up_ff, pend_ff;
   logic                    rsp_tvalid_ff;
   logic [31:0]             rsp_tdata_ff;

   run_entry_type           mem [MAX_RUNS];
   run_entry_type           rd_data_ff;
   logic [IDX_BITS-1:0]     rd_addr, wr_addr;
   logic                    wr_en;
   run_entry_type           wr_data;

   logic                    rsp_free, bad_v, rsp_load;
   logic [POS_BITS-1:0]     end_v, lo_v, hi_v, total_in;
   logic [CNT_BITS:0]       n_v;
   logic [CNT_BITS-1:0]     p_v, tail_dst_v, tail_len_v, jn_v;

   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // Range checks, run bounds and table arithmetic
   always_comb begin
      bad_v = (first_ff == '0) || (first_ff > last_ff) || (last_ff > domain_ff);
      end_v = (scan_ff < runs_ff) ? rd_data_ff.start - POS_BITS'(1) : domain_ff;
      lo_v  = (prev_ff.start > first_ff) ? prev_ff.start : first_ff;
      hi_v  = (end_v < last_ff) ? end_v : last_ff;
      p_v   = i_ff + CNT_BITS'(left_ff);
      jn_v  = j_ff + CNT_BITS'(1);
      tail_dst_v = p_v + CNT_BITS'(1) + CNT_BITS'(right_ff);
      tail_len_v = runs_ff - jn_v;
      n_v   = {1'b0, tail_dst_v} + {1'b0, tail_len_v};
      total_in = total_ff - removed_ff + (cmd_ff ? len_ff : '0);
   end

   // Load a result when the output register is free
   assign rsp_load = rsp_free && (((state_ff == S_CHECK) && bad_v)
                     || ((state_ff == S_FULL) && (n_v > (CNT_BITS+1)'(MAX_RUNS)))
                     || (state_ff == S_FIN));

   // Run table port selection
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data_ff;
      unique case (state_ff)
         S_SCAN: rd_addr = scan_ff[IDX_BITS-1:0] + IDX_BITS'(1);
         S_COPY: begin
            rd_addr = cp_src_ff[IDX_BITS-1:0];
            wr_en   = pend_ff;
            wr_addr = pend_dst_ff[IDX_BITS-1:0];
         end
         S_INIT: begin
            wr_en   = 1'b1;
            wr_data = '{start: POS_BITS'(1), mark: 1'b1};
         end
         S_NEW0: begin
            wr_en   = 1'b1;
            wr_addr = p_ff[IDX_BITS-1:0];
            wr_data = '{start: first_ff, mark: cmd_ff};
         end
         S_NEW1: begin
            wr_en   = 1'b1;
            wr_addr = p_ff[IDX_BITS-1:0] + IDX_BITS'(1);
            wr_data = '{start: last_ff + POS_BITS'(1), mark: mj_ff};
         end
         default: ;
      endcase
   end

   // Run table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         domain_ff     <= DOMAIN_RESET;
         total_ff      <= DOMAIN_RESET;
         runs_ff       <= CNT_BITS'(1);
         rsp_tvalid_ff <= 1'b0;
         acc_v_ff      <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_load || (rsp_tvalid_ff && !rsp_tready);
         // accumulate marked positions covered by the range
         acc_v_ff <= (state_ff == S_SCAN) && have_prev_ff && prev_ff.mark
                     && (hi_v >= lo_v);
         if (acc_v_ff) begin
            removed_ff <= removed_ff + (hi_ff - lo_ff) + POS_BITS'(1);
         end
         unique case (state_ff)
            S_INIT: state_ff <= S_IDLE;
            S_IDLE: begin
               if (csr_valid) begin
                  domain_ff <= csr_data;
                  total_ff  <= csr_data;
                  runs_ff   <= CNT_BITS'(1);
                  state_ff  <= S_INIT;
               end else if (req_tvalid) begin
                  cmd_ff   <= req_tdata[0];
                  first_ff <= req_tdata[30:1];
                  last_ff  <= req_tdata[60:31];
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               len_ff       <= last_ff - first_ff + POS_BITS'(1);
               removed_ff   <= '0;
               scan_ff      <= '0;
               have_prev_ff <= 1'b0;
               i_ff         <= '0;
               j_ff         <= '0;
               if (!bad_v) begin
                  state_ff <= S_SCAN;
               end else if (rsp_free) begin
                  rsp_tdata_ff  <= {ST_BAD_RANGE, total_ff};
                  state_ff      <= S_IDLE;
               end
            end
            S_SCAN: begin
               // settle the run before the one just read
               if (have_prev_ff) begin
                  if (prev_ff.start <= first_ff) begin
                     i_ff    <= scan_ff - CNT_BITS'(1);
                     left_ff <= prev_ff.start < first_ff;
                  end
                  if (prev_ff.start <= last_ff) begin
                     j_ff     <= scan_ff - CNT_BITS'(1);
                     mj_ff    <= prev_ff.mark;
                     right_ff <= end_v != last_ff;
                  end
                  lo_ff    <= lo_v;
                  hi_ff    <= hi_v;
               end
               prev_ff      <= rd_data_ff;
               have_prev_ff <= 1'b1;
               scan_ff      <= scan_ff + CNT_BITS'(1);
               if (scan_ff == runs_ff) begin
                  state_ff <= S_FULL;
               end
            end
            S_FULL: begin
               p_ff        <= p_v;
               new_runs_ff <= n_v[CNT_BITS-1:0];
               cnt_ff      <= tail_len_v;
               pend_ff     <= 1'b0;
               dir_up_ff   <= tail_dst_v < jn_v;
               if (tail_dst_v < jn_v) begin
                  cp_src_ff <= jn_v;
                  cp_dst_ff <= tail_dst_v;
               end else begin
                  cp_src_ff <= runs_ff - CNT_BITS'(1);
                  cp_dst_ff <= n_v[CNT_BITS-1:0] - CNT_BITS'(1);
               end
               if (n_v > (CNT_BITS+1)'(MAX_RUNS)) begin
                  if (rsp_free) begin
                     rsp_tdata_ff  <= {ST_FULL, total_ff};
                     state_ff      <= S_IDLE;
                  end
               end else if (tail_len_v == '0 || tail_dst_v == jn_v) begin
                  state_ff <= S_NEW0;
               end else begin
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               // move the runs behind the range, one read and one write a cycle
               pend_ff <= cnt_ff != '0;
               if (cnt_ff != '0) begin
                  pend_dst_ff <= cp_dst_ff;
                  cnt_ff      <= cnt_ff - CNT_BITS'(1);
                  if (dir_up_ff) begin
                     cp_src_ff <= cp_src_ff + CNT_BITS'(1);
                     cp_dst_ff <= cp_dst_ff + CNT_BITS'(1);
                  end else begin
                     cp_src_ff <= cp_src_ff - CNT_BITS'(1);
                     cp_dst_ff <= cp_dst_ff - CNT_BITS'(1);
                  end
               end else if (!pend_ff) begin
                  state_ff <= S_NEW0;
               end
            end
            S_NEW0: state_ff <= right_ff ? S_NEW1 : S_FIN;
            S_NEW1: state_ff <= S_FIN;
            S_FIN: begin
               if (rsp_free) begin
                  total_ff      <= total_in;
                  runs_ff       <= new_runs_ff;
                  rsp_tdata_ff  <= {ST_OK, total_in};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_runs_range: assert property (@(posedge clock) disable iff (reset)
      (runs_ff != '0) && (runs_ff <= CNT_BITS'(MAX_RUNS)))
      else $error("run count out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:30] == ST_OK || rsp_tdata[31:30] == ST_BAD_RANGE
                      || rsp_tdata[31:30] == ST_FULL))
      else $error("undefined status code");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (state_ff == S_IDLE)) |-> (rsp_tdata[29:0] <= domain_ff))
      else $error("marked count exceeds domain");

endmodule
`default_nettype wire
